// File: rtl/lspv_pkg.sv
package lspv_pkg;

    localparam int ADDR_BITS   = 16;
    localparam int FRAC_BITS   = 16;
    localparam int PHASE_W     = 32;
    localparam int STORE_DEPTH = 1 << ADDR_BITS;
    localparam int STEP_W      = 20;
    localparam int STEP_UP     = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int STEP_DOWN   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    // positions carry sign and two bits of headroom for 2*end - phase
    localparam int POS_W       = (PHASE_W > 16 + FRAC_BITS) ? PHASE_W : 16 + FRAC_BITS;
    localparam int PW          = POS_W + 3;
    localparam int PROD_W      = 17 + FRAC_BITS + 1;
    localparam int P1_W        = 33;
    localparam int P2_W        = 50;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = 1;
    localparam int Q_CNT_W     = 2;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2,
        OP_KILL  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        LOOP_NONE     = 2'd0,
        LOOP_FORWARD  = 2'd1,
        LOOP_SUSTAIN  = 2'd2,
        LOOP_PINGPONG = 2'd3
    } t_loop;

    typedef enum logic [2:0] {
        REG_SAMPLE_LENGTH = 3'd0,
        REG_LOOP_BEGIN    = 3'd1,
        REG_LOOP_FINISH   = 3'd2,
        REG_LOOP_MODE     = 3'd3,
        REG_VOICE_GAIN    = 3'd4
    } t_reg;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ0,
        BK_READ1,
        BK_MUL0,
        BK_MUL1,
        BK_FINISH
    } t_bk_state;

    typedef struct packed {
        t_op                   op;
        logic [ADDR_BITS-1:0]  addr;
        logic signed [15:0]    data;
        logic [PHASE_W-1:0]    step;
        logic [15:0]           env;
        logic                  env_idle;
        logic                  held;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_out;

    typedef struct packed {
        logic [15:0] sample_length;
        logic [15:0] loop_begin;
        logic [15:0] loop_finish;
        t_loop       loop_mode;
        logic [15:0] voice_gain;
    } t_cfg;

    // bring the 4.16 step to FRAC_BITS fraction bits
    function automatic logic [PHASE_W-1:0] f_step(input logic [STEP_W-1:0] s);
        logic [PHASE_W-1:0] w;
        w = PHASE_W'(s);
        return (w << STEP_UP) >> STEP_DOWN;
    endfunction

    function automatic logic signed [PW-1:0] f_pos(input logic [15:0] v);
        logic [PW-1:0] w;
        w = PW'(v) << FRAC_BITS;
        return signed'(w);
    endfunction

    function automatic logic [PHASE_W-1:0] f_sat_phase(input logic signed [PW-1:0] p);
        logic [PHASE_W-1:0] r;
        if (p[PW-1]) begin
            r = '0;
        end else if (|p[PW-2:PHASE_W]) begin
            r = '1;
        end else begin
            r = p[PHASE_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/lspv_front.sv
module lspv_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_req_type,
    input  logic [15:0]         i_word_addr,
    input  logic signed [15:0]  i_word_data,
    input  logic [19:0]         i_phase_step,
    input  logic [15:0]         i_envelope,
    input  logic                i_envelope_idle,
    input  logic                i_note_held,
    input  logic                i_pop,
    output lspv_pkg::t_q_out    o_q
);

    lspv_pkg::t_cmd                  w_cmd;
    logic [31:0]                     w_addr_ext;
    lspv_pkg::t_cmd                  r_q [lspv_pkg::Q_DEPTH];
    logic [lspv_pkg::Q_PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [lspv_pkg::Q_PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [lspv_pkg::Q_CNT_W-1:0]    r_count, n_count;
    logic                            w_push;
    logic                            w_pop;

    // classify the request and keep only the fields its operation uses
    always_comb begin
        w_addr_ext   = 32'(i_word_addr);
        w_cmd        = '0;
        w_cmd.op     = lspv_pkg::t_op'(i_req_type);
        unique case (w_cmd.op)
            lspv_pkg::OP_WRITE: begin
                w_cmd.addr = w_addr_ext[lspv_pkg::ADDR_BITS-1:0];
                w_cmd.data = i_word_data;
            end
            lspv_pkg::OP_TICK: begin
                w_cmd.step     = lspv_pkg::f_step(i_phase_step);
                w_cmd.env      = i_envelope;
                w_cmd.env_idle = i_envelope_idle;
                w_cmd.held     = i_note_held;
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready = (r_count != lspv_pkg::Q_CNT_W'(lspv_pkg::Q_DEPTH));
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    assign o_q.valid = (r_count != '0);
    assign o_q.cmd   = r_q[r_rd_ptr];

endmodule

// File: rtl/lspv_back.sv
module lspv_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lspv_pkg::t_cfg      i_cfg,
    input  lspv_pkg::t_q_out    i_q,
    output logic                o_pop,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic signed [15:0]  o_sample_out,
    output logic                o_voice_active
);

    localparam int PW     = lspv_pkg::PW;
    localparam int PROD_W = lspv_pkg::PROD_W;
    localparam int P1_W   = lspv_pkg::P1_W;
    localparam int P2_W   = lspv_pkg::P2_W;
    localparam int FB     = lspv_pkg::FRAC_BITS;
    localparam int PH_W   = lspv_pkg::PHASE_W;
    localparam int AB     = lspv_pkg::ADDR_BITS;

    lspv_pkg::t_bk_state        r_state, n_state;
    logic [PH_W-1:0]            r_phase, n_phase;
    logic                       r_fwd, n_fwd;
    logic                       r_playing, n_playing;
    lspv_pkg::t_loop            r_mode, n_mode;
    lspv_pkg::t_cmd             r_cmd, n_cmd;
    logic                       r_out_valid, n_out_valid;
    logic signed [15:0]         r_out_sample, n_out_sample;
    logic                       r_out_active, n_out_active;

    logic signed [15:0]         r_mem [lspv_pkg::STORE_DEPTH];
    logic signed [15:0]         r_rd_data;
    logic signed [15:0]         r_s0;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [P1_W-1:0]     r_p1;
    logic signed [P2_W-1:0]     r_p2;
    logic signed [PW-1:0]       r_sum, r_dif;

    logic                       mem_we;
    logic [AB-1:0]              mem_raddr;
    logic [PH_W-1:0]            idx_w, idx_m1;
    logic signed [16:0]         diff;
    logic signed [FB:0]         frac_s;
    logic signed [PROD_W-1:0]   prod_c;
    logic signed [PROD_W-1:0]   interp_w;
    logic signed [15:0]         interp;
    logic signed [P1_W-1:0]     p1_c;
    logic signed [P2_W-1:0]     p2_c;
    logic signed [P2_W:0]       rnd, scaled;
    logic signed [15:0]         val;
    logic signed [PW-1:0]       lend, lbeg, slen, ph;
    logic                       stop;
    logic                       can_out;
    logic                       loop_bad;

    // read addresses: lower neighbor clamps at index zero
    always_comb begin
        idx_w     = r_phase >> FB;
        idx_m1    = (idx_w == '0) ? '0 : idx_w - PH_W'(1);
        mem_raddr = (r_state == lspv_pkg::BK_IDLE) ? idx_m1[AB-1:0] : idx_w[AB-1:0];
    end

    // interpolation and gain datapath
    always_comb begin
        diff     = {r_rd_data[15], r_rd_data} - {r_s0[15], r_s0};
        frac_s   = signed'({1'b0, r_phase[FB-1:0]});
        prod_c   = diff * frac_s;
        interp_w = PROD_W'(r_s0) + (r_prod >>> FB);
        interp   = interp_w[15:0];
        p1_c     = interp * signed'({1'b0, i_cfg.voice_gain});
        p2_c     = r_p1 * signed'({1'b0, r_cmd.env});
        rnd      = {r_p2[P2_W-1], r_p2} + {{(P2_W - 29){1'b0}}, 1'b1, 29'd0};
        scaled   = rnd >>> 30;
        if (scaled > (P2_W + 1)'(32767)) begin
            val = 16'sh7FFF;
        end else if (scaled < -(P2_W + 1)'(32768)) begin
            val = -16'sh8000;
        end else begin
            val = scaled[15:0];
        end
    end

    always_comb begin
        lend     = lspv_pkg::f_pos(i_cfg.loop_finish);
        lbeg     = lspv_pkg::f_pos(i_cfg.loop_begin);
        slen     = lspv_pkg::f_pos(i_cfg.sample_length);
        loop_bad = (i_cfg.loop_finish > i_cfg.sample_length) ||
                   (i_cfg.loop_finish <= i_cfg.loop_begin);
        can_out  = !r_out_valid || i_out_ready;
    end

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_fwd        = r_fwd;
        n_playing    = r_playing;
        n_mode       = r_mode;
        n_cmd        = r_cmd;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_sample = r_out_sample;
        n_out_active = r_out_active;
        o_pop        = 1'b0;
        mem_we       = 1'b0;
        ph           = r_sum;
        stop         = 1'b0;

        unique case (r_state)
            lspv_pkg::BK_IDLE: begin
                if (i_q.valid && can_out) begin
                    o_pop        = 1'b1;
                    n_cmd        = i_q.cmd;
                    n_out_sample = '0;
                    unique case (i_q.cmd.op)
                        lspv_pkg::OP_WRITE: begin
                            mem_we       = 1'b1;
                            n_out_valid  = 1'b1;
                            n_out_active = r_playing;
                        end
                        lspv_pkg::OP_START: begin
                            n_phase      = PH_W'(1) << FB;
                            n_fwd        = 1'b1;
                            n_playing    = 1'b1;
                            n_mode       = loop_bad ? lspv_pkg::LOOP_NONE : i_cfg.loop_mode;
                            n_out_valid  = 1'b1;
                            n_out_active = 1'b1;
                        end
                        lspv_pkg::OP_TICK: begin
                            if (r_playing) begin
                                n_state = lspv_pkg::BK_READ0;
                            end else begin
                                n_out_valid  = 1'b1;
                                n_out_active = 1'b0;
                            end
                        end
                        lspv_pkg::OP_KILL: begin
                            n_playing    = 1'b0;
                            n_out_valid  = 1'b1;
                            n_out_active = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            lspv_pkg::BK_READ0: n_state = lspv_pkg::BK_READ1;
            lspv_pkg::BK_READ1: n_state = lspv_pkg::BK_MUL0;
            lspv_pkg::BK_MUL0:  n_state = lspv_pkg::BK_MUL1;
            lspv_pkg::BK_MUL1:  n_state = lspv_pkg::BK_FINISH;
            lspv_pkg::BK_FINISH: begin
                if (can_out) begin
                    case (r_mode)
                        lspv_pkg::LOOP_FORWARD: begin
                            if (r_sum >= lend) ph = r_sum - lend + lbeg;
                        end
                        lspv_pkg::LOOP_SUSTAIN: begin
                            if (r_cmd.held) begin
                                if (r_sum >= lend) ph = r_sum - lend + lbeg;
                            end else begin
                                // released: fall back to one-shot play
                                n_mode = lspv_pkg::LOOP_NONE;
                                stop   = (r_sum >= slen);
                            end
                        end
                        lspv_pkg::LOOP_PINGPONG: begin
                            if (r_fwd) begin
                                if (r_sum >= lend) begin
                                    ph    = (lend <<< 1) - r_sum;
                                    n_fwd = 1'b0;
                                end
                            end else begin
                                ph = r_dif;
                                if (r_dif <= lbeg) begin
                                    ph    = (lbeg <<< 1) - r_dif;
                                    n_fwd = 1'b1;
                                end
                            end
                        end
                        default: begin
                            stop = (r_sum >= slen);
                        end
                    endcase

                    n_out_valid  = 1'b1;
                    n_out_sample = '0;
                    if (stop) begin
                        n_playing = 1'b0;
                    end else begin
                        n_phase = lspv_pkg::f_sat_phase(ph);
                        if (r_cmd.env_idle) begin
                            n_playing = 1'b0;
                        end else begin
                            n_out_sample = val;
                        end
                    end
                    n_out_active = n_playing;
                    n_state      = lspv_pkg::BK_IDLE;
                end
            end
            default: n_state = lspv_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lspv_pkg::BK_IDLE;
            r_phase     <= '0;
            r_fwd       <= 1'b1;
            r_playing   <= 1'b0;
            r_mode      <= lspv_pkg::LOOP_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_fwd       <= n_fwd;
            r_playing   <= n_playing;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_out_sample <= n_out_sample;
        r_out_active <= n_out_active;
        case (r_state)
            lspv_pkg::BK_READ0: begin
                r_s0  <= r_rd_data;
                r_sum <= signed'(PW'(r_phase)) + signed'(PW'(r_cmd.step));
                r_dif <= signed'(PW'(r_phase)) - signed'(PW'(r_cmd.step));
            end
            lspv_pkg::BK_READ1: r_prod <= prod_c;
            lspv_pkg::BK_MUL0:  r_p1   <= p1_c;
            lspv_pkg::BK_MUL1:  r_p2   <= p2_c;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_q.cmd.addr] <= i_q.cmd.data;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample_out   = r_out_sample;
    assign o_voice_active = r_out_active;

endmodule

// File: rtl/looped_sample_playback_voice_top.sv
// Single sample playback voice with forward, sustain and ping-pong loops.
// Request channel (i_in_valid / o_in_ready): write a sample word, start,
// tick or kill. Every request yields exactly one result on the result
// channel (o_out_valid / i_out_ready): o_sample_out is nonzero only for a
// tick of a playing voice, o_voice_active is the playing flag afterwards.
// Requests enter a two-entry queue and are carried out in order by the
// playback engine. Write, start, kill and a tick of a stopped voice finish
// in the idle state with a registered result and sustain one per cycle while
// results are taken. A tick of a playing voice steps on through READ0,
// READ1, MUL0, MUL1 and FINISH (two reads of the single sample memory port,
// three registered multiplies, one phase update); no new request is taken
// until it is done. A stalled result stays in the output register; the
// engine holds, the queue fills and o_in_ready drops once it is full.
// Reset (i_rst_n low, synchronous) clears the voice and the registers to
// their defaults; the sample memory is not cleared and must be written
// before it is played. Registers sit on the APB port at byte address 4*i
// and may be written only while the voice has no request in flight.
module looped_sample_playback_voice_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_req_type,
    input  logic [15:0]         i_word_addr,
    input  logic signed [15:0]  i_word_data,
    input  logic [19:0]         i_phase_step,
    input  logic [15:0]         i_envelope,
    input  logic                i_envelope_idle,
    input  logic                i_note_held,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [15:0]  o_sample_out,
    output logic                o_voice_active,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [15:0]         r_sample_length;
    logic [15:0]         r_loop_begin;
    logic [15:0]         r_loop_finish;
    logic [1:0]          r_loop_mode;
    logic [15:0]         r_voice_gain;
    logic                w_cfg_wr;
    lspv_pkg::t_reg      w_reg;
    lspv_pkg::t_cfg      w_cfg;
    lspv_pkg::t_q_out    w_q;
    logic                w_pop;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_reg    = lspv_pkg::t_reg'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_length <= 16'd1;
            r_loop_begin    <= '0;
            r_loop_finish   <= '0;
            r_loop_mode     <= lspv_pkg::LOOP_NONE;
            r_voice_gain    <= 16'd32768;
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                lspv_pkg::REG_SAMPLE_LENGTH: r_sample_length <= pwdata[15:0];
                lspv_pkg::REG_LOOP_BEGIN:    r_loop_begin    <= pwdata[15:0];
                lspv_pkg::REG_LOOP_FINISH:   r_loop_finish   <= pwdata[15:0];
                lspv_pkg::REG_LOOP_MODE:     r_loop_mode     <= pwdata[1:0];
                lspv_pkg::REG_VOICE_GAIN:    r_voice_gain    <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            lspv_pkg::REG_SAMPLE_LENGTH: prdata = 32'(r_sample_length);
            lspv_pkg::REG_LOOP_BEGIN:    prdata = 32'(r_loop_begin);
            lspv_pkg::REG_LOOP_FINISH:   prdata = 32'(r_loop_finish);
            lspv_pkg::REG_LOOP_MODE:     prdata = 32'(r_loop_mode);
            lspv_pkg::REG_VOICE_GAIN:    prdata = 32'(r_voice_gain);
            default:                     prdata = '0;
        endcase
    end

    always_comb begin
        w_cfg.sample_length = r_sample_length;
        w_cfg.loop_begin    = r_loop_begin;
        w_cfg.loop_finish   = r_loop_finish;
        w_cfg.loop_mode     = lspv_pkg::t_loop'(r_loop_mode);
        w_cfg.voice_gain    = r_voice_gain;
    end

    lspv_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_word_addr     (i_word_addr),
        .i_word_data     (i_word_data),
        .i_phase_step    (i_phase_step),
        .i_envelope      (i_envelope),
        .i_envelope_idle (i_envelope_idle),
        .i_note_held     (i_note_held),
        .i_pop           (w_pop),
        .o_q             (w_q)
    );

    lspv_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_q            (w_q),
        .o_pop          (w_pop),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_sample_out   (o_sample_out),
        .o_voice_active (o_voice_active)
    );

    a_inactive_is_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_voice_active |-> o_sample_out == 16'sd0)
        else $error("inactive voice produced a nonzero sample");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q.valid)
        else $error("engine took a request from an empty queue");

    a_reset_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_out_valid && o_in_ready)
        else $error("result or full queue left over after reset");

endmodule
